/* design/assert_macros.svh */
// Assertion macros used by the checker of the face normal engine.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FFN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FFN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ffn_pkg.sv */
// Shared types, codes and sizes of the face normal engine.
// Depends on nothing; used by the top level and the checker.
`default_nettype none

package ffn_pkg;

  localparam int unsigned VERTEX_COUNT = 1024;
  localparam int unsigned ADDR_W       = $clog2(VERTEX_COUNT);
  localparam int unsigned VERT_W       = 96;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_FACE   = 2'd1,
    OP_READ   = 2'd2,
    OP_IGNORE = 2'd3
  } ffn_op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [9:0]         vertex_index;
    logic [9:0]         face_v0;
    logic [9:0]         face_v1;
    logic [9:0]         face_v2;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_face;
  } ffn_in_t;

  typedef struct packed {
    logic signed [31:0] read_x;
    logic signed [31:0] read_y;
    logic signed [31:0] read_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               degenerate;
    logic               mesh_done;
  } ffn_out_t;

  function automatic logic in_range(logic [9:0] idx);
    return 32'(idx) < VERTEX_COUNT;
  endfunction

endpackage

`default_nettype wire

/* design/ffn_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; the vertex stores are instances of it.
`default_nettype none

module ffn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/flat_face_normal_engine.sv */
// Top level of the face normal engine: sequencer, shared arithmetic and two vertex RAMs.
// Depends on ffn_pkg and ffn_ram.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i  (ffn_in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (ffn_out_t)
//
// A write item goes straight into the position RAM and the block stays idle. A read item
// reads both RAMs, captures the data and loads the output register. A face item gathers
// three positions from the position RAM, forms the cross product on the shared 32x32
// multiplier, checks the normalizing shift and shifts one bit at a time, takes the
// squares, runs the bit-serial square root, runs the serial divider once per component,
// writes the normal to the normal RAM at each in-range corner and loads the output
// register; when the cross product is zero it goes from the shift check to the RAM writes.
// After reset the normal RAM is swept to zero, one entry a cycle, while in_stall_o is high.
// A stalled output holds its item; the block takes new items meanwhile and waits only
// when a second result is ready before the first has been taken.
`default_nettype none

module flat_face_normal_engine (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire ffn_pkg::ffn_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output ffn_pkg::ffn_out_t     out_data_o
);
  import ffn_pkg::*;

  typedef enum logic [17:0] {
    S_CLR   = 18'h00001,
    S_IDLE  = 18'h00002,
    S_RD    = 18'h00004,
    S_RDCAP = 18'h00008,
    S_RDA   = 18'h00010,
    S_RDB   = 18'h00020,
    S_RDC   = 18'h00040,
    S_CAPC  = 18'h00080,
    S_MUL   = 18'h00100,
    S_ACC   = 18'h00200,
    S_NORM  = 18'h00400,
    S_SQ    = 18'h00800,
    S_SQACC = 18'h01000,
    S_SQRT  = 18'h02000,
    S_DSET  = 18'h04000,
    S_DIV   = 18'h08000,
    S_WRN   = 18'h10000,
    S_FIN   = 18'h20000
  } state_e;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(VERTEX_COUNT - 1);

  state_e state_q, state_d;

  // Control registers.
  logic [ADDR_W-1:0] clr_q;
  logic              out_valid_q;
  logic [1:0]        kstep_q;
  logic [2:0]        mstep_q;
  logic [4:0]        sb_q;
  logic [4:0]        dc_q;

  // Datapath registers.
  ffn_in_t            item_q;
  logic [2:0]         ok_q;
  logic               rd_ok_q;
  ffn_out_t           res_q;
  ffn_out_t           out_q;
  logic signed [32:0] pa_q [3];
  logic signed [32:0] d_q  [3];
  logic signed [32:0] e_q  [3];
  logic [63:0]        prod_q;
  logic               pneg_q;
  logic signed [65:0] acc_q;
  logic [64:0]        m_q  [3];
  logic [2:0]         neg_q;
  logic               degen_q;
  logic [63:0]        s_q;
  logic [63:0]        rem_q;
  logic [63:0]        root_q;
  logic [31:0]        len_q;
  logic [31:0]        dr_q;
  logic [31:0]        dn_q;
  logic [31:0]        dq_q;
  logic [31:0]        n_q  [3];

  logic accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // RAM ports.
  logic              pos_we, pos_re, nrm_we, nrm_re;
  logic [ADDR_W-1:0] pos_waddr, pos_raddr, nrm_waddr, nrm_raddr;
  logic [VERT_W-1:0] pos_wdata, pos_rdata, nrm_wdata, nrm_rdata;

  logic [9:0] corner_idx;
  logic       corner_ok;
  always_comb begin
    case (kstep_q)
      2'd0:    begin corner_idx = item_q.face_v0; corner_ok = ok_q[0]; end
      2'd1:    begin corner_idx = item_q.face_v1; corner_ok = ok_q[1]; end
      default: begin corner_idx = item_q.face_v2; corner_ok = ok_q[2]; end
    endcase
  end

  always_comb begin
    pos_we    = accept && (in_data_i.operation == OP_WRITE) &&
                in_range(in_data_i.vertex_index);
    pos_waddr = ADDR_W'(in_data_i.vertex_index);
    pos_wdata = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
    pos_re    = 1'b0;
    pos_raddr = ADDR_W'(item_q.vertex_index);
    case (state_q)
      S_RD:    pos_re = 1'b1;
      S_RDA:   begin pos_re = 1'b1; pos_raddr = ADDR_W'(item_q.face_v0); end
      S_RDB:   begin pos_re = 1'b1; pos_raddr = ADDR_W'(item_q.face_v1); end
      S_RDC:   begin pos_re = 1'b1; pos_raddr = ADDR_W'(item_q.face_v2); end
      default: pos_re = 1'b0;
    endcase
    nrm_re    = (state_q == S_RD);
    nrm_raddr = ADDR_W'(item_q.vertex_index);
    nrm_we    = 1'b0;
    nrm_waddr = clr_q;
    nrm_wdata = '0;
    case (state_q)
      S_CLR:   nrm_we = 1'b1;
      S_WRN:   begin
        nrm_we    = corner_ok;
        nrm_waddr = ADDR_W'(corner_idx);
        nrm_wdata = {n_q[2], n_q[1], n_q[0]};
      end
      default: nrm_we = 1'b0;
    endcase
  end

  ffn_ram #(.WIDTH(VERT_W), .DEPTH(VERTEX_COUNT)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  ffn_ram #(.WIDTH(VERT_W), .DEPTH(VERTEX_COUNT)) u_nrm_ram (
    .clk_i   (clk_i),
    .we_i    (nrm_we),
    .waddr_i (nrm_waddr),
    .wdata_i (nrm_wdata),
    .re_i    (nrm_re),
    .raddr_i (nrm_raddr),
    .rdata_o (nrm_rdata)
  );

  // Positions of a corner that lies outside the store read as zero.
  function automatic logic signed [32:0] sx(logic [31:0] w, logic ok);
    return ok ? $signed({w[31], w}) : '0;
  endfunction

  function automatic logic [31:0] mag33(logic signed [32:0] v);
    return v[32] ? 32'(-v) : v[31:0];
  endfunction

  // Cross product terms: component k is d[i]*e[j] - d[j]*e[i], one product per step.
  logic signed [32:0] opa, opb;
  always_comb begin
    case (mstep_q)
      3'd0:    begin opa = d_q[1]; opb = e_q[2]; end
      3'd1:    begin opa = d_q[2]; opb = e_q[1]; end
      3'd2:    begin opa = d_q[2]; opb = e_q[0]; end
      3'd3:    begin opa = d_q[0]; opb = e_q[2]; end
      3'd4:    begin opa = d_q[0]; opb = e_q[1]; end
      default: begin opa = d_q[1]; opb = e_q[0]; end
    endcase
  end

  logic [1:0]  kterm;
  assign kterm = mstep_q[2:1];

  // The squares take one component per step, so the step count picks it directly.
  logic [1:0]  ksq;
  assign ksq = mstep_q[1:0];

  // One shared multiplier feeds both the cross product and the squares.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    if (state_q == S_SQ) begin
      mul_a = {1'b0, m_q[ksq][30:0]};
      mul_b = {1'b0, m_q[ksq][30:0]};
    end else begin
      mul_a = mag33(opa);
      mul_b = mag33(opb);
    end
  end
  assign mul_p = mul_a * mul_b;

  logic signed [65:0] pval, acc_new;
  logic [64:0]        acc_mag;
  assign pval    = pneg_q ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q});
  assign acc_new = mstep_q[0] ? acc_q + pval : pval;
  assign acc_mag = acc_new[65] ? 65'(-acc_new) : acc_new[64:0];

  logic [64:0] orv;
  assign orv = m_q[0] | m_q[1] | m_q[2];
  logic norm_hi, norm_lo;
  assign norm_hi = |orv[64:31];
  assign norm_lo = !orv[30];

  // Square root, one result bit per cycle.
  logic [63:0] sq_bit, sq_t, root_new;
  logic        sq_ge;
  assign sq_bit   = 64'(1) << {sb_q, 1'b0};
  assign sq_t     = root_q + sq_bit;
  assign sq_ge    = rem_q >= sq_t;
  assign root_new = sq_ge ? (root_q >> 1) + sq_bit : root_q >> 1;

  // Rounded quotient (m * 2^30 + len/2) / len, one quotient bit per cycle.
  logic [61:0] num;
  logic [32:0] dv_t, dv_r;
  logic        dv_ge;
  logic [31:0] q_new;
  assign num   = {1'b0, m_q[kstep_q][30:0], 30'b0} + 62'(len_q >> 1);
  assign dv_t  = {dr_q, dn_q[31]};
  assign dv_ge = dv_t >= {1'b0, len_q};
  assign dv_r  = dv_ge ? dv_t - {1'b0, len_q} : dv_t;
  assign q_new = {dq_q[30:0], dv_ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:   if (clr_q == CLR_LAST) state_d = S_IDLE;
      S_IDLE:  begin
        if (accept) begin
          case (in_data_i.operation)
            OP_FACE: state_d = S_RDA;
            OP_READ: state_d = S_RD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD:    state_d = S_RDCAP;
      S_RDCAP: state_d = S_FIN;
      S_RDA:   state_d = S_RDB;
      S_RDB:   state_d = S_RDC;
      S_RDC:   state_d = S_CAPC;
      S_CAPC:  state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = (mstep_q == 3'd5) ? S_NORM : S_MUL;
      S_NORM:  begin
        if (orv == '0) begin
          state_d = S_WRN;
        end else if (!norm_hi && !norm_lo) begin
          state_d = S_SQ;
        end
      end
      S_SQ:    state_d = S_SQACC;
      S_SQACC: state_d = (mstep_q == 3'd2) ? S_SQRT : S_SQ;
      S_SQRT:  if (sb_q == '0) state_d = S_DSET;
      S_DSET:  state_d = S_DIV;
      S_DIV:   if (dc_q == 5'd31) state_d = (kstep_q == 2'd2) ? S_WRN : S_DSET;
      S_WRN:   if (kstep_q == 2'd2) state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      kstep_q     <= '0;
      mstep_q     <= '0;
      sb_q        <= '0;
      dc_q        <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR:   clr_q <= clr_q + 1'b1;
        S_IDLE:  begin
          kstep_q <= '0;
          mstep_q <= '0;
        end
        S_ACC:   mstep_q <= (mstep_q == 3'd5) ? 3'd0 : mstep_q + 3'd1;
        S_SQACC: begin
          mstep_q <= mstep_q + 3'd1;
          sb_q    <= 5'd31;
        end
        S_SQRT:  sb_q <= sb_q - 5'd1;
        S_DSET:  dc_q <= '0;
        S_DIV:   begin
          dc_q <= dc_q + 5'd1;
          if (dc_q == 5'd31) begin
            kstep_q <= (kstep_q == 2'd2) ? 2'd0 : kstep_q + 2'd1;
          end
        end
        S_WRN:   kstep_q <= kstep_q + 2'd1;
        default: clr_q <= clr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE:  begin
        if (accept) begin
          item_q  <= in_data_i;
          rd_ok_q <= in_range(in_data_i.vertex_index);
          ok_q    <= {in_range(in_data_i.face_v2), in_range(in_data_i.face_v1),
                      in_range(in_data_i.face_v0)};
        end
      end
      S_RDCAP: begin
        res_q.read_x     <= rd_ok_q ? pos_rdata[31:0]  : '0;
        res_q.read_y     <= rd_ok_q ? pos_rdata[63:32] : '0;
        res_q.read_z     <= rd_ok_q ? pos_rdata[95:64] : '0;
        res_q.normal_x   <= rd_ok_q ? nrm_rdata[31:0]  : '0;
        res_q.normal_y   <= rd_ok_q ? nrm_rdata[63:32] : '0;
        res_q.normal_z   <= rd_ok_q ? nrm_rdata[95:64] : '0;
        res_q.degenerate <= 1'b0;
        res_q.mesh_done  <= 1'b0;
      end
      S_RDB:   begin
        pa_q[0] <= sx(pos_rdata[31:0],  ok_q[0]);
        pa_q[1] <= sx(pos_rdata[63:32], ok_q[0]);
        pa_q[2] <= sx(pos_rdata[95:64], ok_q[0]);
      end
      S_RDC:   begin
        d_q[0] <= pa_q[0] - sx(pos_rdata[31:0],  ok_q[1]);
        d_q[1] <= pa_q[1] - sx(pos_rdata[63:32], ok_q[1]);
        d_q[2] <= pa_q[2] - sx(pos_rdata[95:64], ok_q[1]);
      end
      S_CAPC:  begin
        e_q[0] <= pa_q[0] - sx(pos_rdata[31:0],  ok_q[2]);
        e_q[1] <= pa_q[1] - sx(pos_rdata[63:32], ok_q[2]);
        e_q[2] <= pa_q[2] - sx(pos_rdata[95:64], ok_q[2]);
      end
      S_MUL:   begin
        prod_q <= mul_p;
        // The second product of each component is subtracted.
        pneg_q <= opa[32] ^ opb[32] ^ mstep_q[0];
      end
      S_ACC:   begin
        acc_q <= acc_new;
        if (mstep_q[0]) begin
          m_q[kterm]   <= acc_mag;
          neg_q[kterm] <= acc_new[65];
        end
      end
      S_NORM:  begin
        degen_q <= (orv == '0);
        s_q     <= '0;
        if (orv == '0) begin
          n_q[0] <= '0;
          n_q[1] <= '0;
          n_q[2] <= '0;
        end else if (norm_hi) begin
          m_q[0] <= m_q[0] >> 1;
          m_q[1] <= m_q[1] >> 1;
          m_q[2] <= m_q[2] >> 1;
        end else if (norm_lo) begin
          m_q[0] <= m_q[0] << 1;
          m_q[1] <= m_q[1] << 1;
          m_q[2] <= m_q[2] << 1;
        end
      end
      S_SQ:    prod_q <= mul_p;
      S_SQACC: begin
        s_q    <= s_q + prod_q;
        rem_q  <= s_q + prod_q;
        root_q <= '0;
      end
      S_SQRT:  begin
        if (sq_ge) begin
          rem_q <= rem_q - sq_t;
        end
        root_q <= root_new;
        len_q  <= root_new[31:0];
      end
      S_DSET:  begin
        dr_q <= {2'b00, num[61:32]};
        dn_q <= num[31:0];
        dq_q <= '0;
      end
      S_DIV:   begin
        dr_q <= dv_r[31:0];
        dn_q <= dn_q << 1;
        dq_q <= q_new;
        if (dc_q == 5'd31) begin
          n_q[kstep_q] <= neg_q[kstep_q] ? 32'(-q_new) : q_new;
        end
      end
      S_WRN:   begin
        res_q.read_x     <= '0;
        res_q.read_y     <= '0;
        res_q.read_z     <= '0;
        res_q.normal_x   <= n_q[0];
        res_q.normal_y   <= n_q[1];
        res_q.normal_z   <= n_q[2];
        res_q.degenerate <= degen_q;
        res_q.mesh_done  <= item_q.last_face;
      end
      S_FIN:   if (out_free) out_q <= res_q;
      default: prod_q <= prod_q;
    endcase
  end

endmodule

`default_nettype wire

/* design/ffn_checker.sv */
// Port-level checker of the face normal engine and its bind to the top level.
// Depends on ffn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ffn_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire ffn_pkg::ffn_in_t in_data_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire ffn_pkg::ffn_out_t out_data_o
);
  import ffn_pkg::*;

  logic acc_in;
  assign acc_in = in_valid_i && !in_stall_o;

  `FFN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output item changed")
  `FFN_ASSERT_NEXT(a_face_busy, clk_i, rst_ni, acc_in && (in_data_i.operation == OP_FACE), in_stall_o, "face item did not hold off input")
  `FFN_ASSERT_NEXT(a_write_free, clk_i, rst_ni, acc_in && (in_data_i.operation == OP_WRITE), !in_stall_o, "write item stalled the input")
  `FFN_ASSERT_NOW(a_write_quiet, clk_i, rst_ni, acc_in && !out_valid_o && (in_data_i.operation == OP_WRITE), ##1 !out_valid_o, "write item produced a result")

endmodule

bind flat_face_normal_engine ffn_checker u_ffn_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench of the flat face normal engine: table-driven directed items,
// then random writes, faces and reads checked against an exact fixed-point predictor.
// Depends on ffn_pkg and the flat_face_normal_engine RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffn_pkg::*;

  localparam int unsigned IDLE_LIMIT = 6000;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 530;

  typedef struct {
    ffn_in_t  item;
    bit       typed;
    ffn_out_t want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  ffn_in_t  in_data = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ffn_out_t out_data;

  // Percent chance per cycle that the sender or the receiver holds off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;

  // Shadow copy of the vertex store, kept in step with accepted items.
  logic signed [31:0] shadow_pos [VERTEX_COUNT][3];
  logic signed [31:0] shadow_nrm [VERTEX_COUNT][3];
  bit                 pos_written [VERTEX_COUNT];
  int unsigned        written_list [$];

  ffn_out_t pending_results [$];

  flat_face_normal_engine uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Floor of the square root, one result bit per pair of input bits.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Unit normal of (a-b) x (a-c), computed exactly on wide signed vectors.
  function automatic void unit_normal(input int unsigned ia, input int unsigned ib,
                                      input int unsigned ic,
                                      output logic signed [31:0] nrm [3],
                                      output logic degen);
    logic signed [69:0] d [3];
    logic signed [69:0] e [3];
    logic signed [69:0] w [3];
    logic [69:0]        mag [3];
    logic [69:0]        shifted;
    logic [63:0]        m [3];
    logic [63:0]        sum_sq;
    logic [63:0]        len;
    logic [63:0]        q;
    int                 blen;
    int                 sh;
    for (int k = 0; k < 3; k++) begin
      d[k] = 70'(shadow_pos[ia][k]) - 70'(shadow_pos[ib][k]);
      e[k] = 70'(shadow_pos[ia][k]) - 70'(shadow_pos[ic][k]);
    end
    w[0] = d[1] * e[2] - d[2] * e[1];
    w[1] = d[2] * e[0] - d[0] * e[2];
    w[2] = d[0] * e[1] - d[1] * e[0];
    blen = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (w[k] < 0) ? 70'(-w[k]) : 70'(w[k]);
      for (int b = 69; b >= 0; b--) begin
        if (mag[k][b]) begin
          if (b + 1 > blen) blen = b + 1;
          break;
        end
      end
    end
    degen = (blen == 0);
    for (int k = 0; k < 3; k++) nrm[k] = '0;
    if (!degen) begin
      sh = 31 - blen;
      sum_sq = '0;
      for (int k = 0; k < 3; k++) begin
        shifted = (sh >= 0) ? (mag[k] << sh) : (mag[k] >> (-sh));
        m[k] = shifted[63:0];
        sum_sq = sum_sq + m[k] * m[k];
      end
      len = floor_sqrt(sum_sq);
      for (int k = 0; k < 3; k++) begin
        q = ((m[k] << 30) + (len >> 1)) / len;
        nrm[k] = (w[k] < 0) ? -32'(q) : 32'(q);
      end
    end
  endfunction

  // Applies one accepted item to the shadow store and returns its result, if any.
  function automatic bit apply_item(input ffn_in_t it, output ffn_out_t res);
    logic signed [31:0] nrm [3];
    logic               degen;
    int unsigned        corner [3];
    res = '0;
    case (ffn_op_e'(it.operation))
      OP_WRITE: begin
        shadow_pos[it.vertex_index][0] = it.pos_x;
        shadow_pos[it.vertex_index][1] = it.pos_y;
        shadow_pos[it.vertex_index][2] = it.pos_z;
        if (!pos_written[it.vertex_index]) written_list.push_back(32'(it.vertex_index));
        pos_written[it.vertex_index] = 1'b1;
        return 1'b0;
      end
      OP_READ: begin
        res.read_x   = shadow_pos[it.vertex_index][0];
        res.read_y   = shadow_pos[it.vertex_index][1];
        res.read_z   = shadow_pos[it.vertex_index][2];
        res.normal_x = shadow_nrm[it.vertex_index][0];
        res.normal_y = shadow_nrm[it.vertex_index][1];
        res.normal_z = shadow_nrm[it.vertex_index][2];
        return 1'b1;
      end
      OP_FACE: begin
        corner[0] = 32'(it.face_v0);
        corner[1] = 32'(it.face_v1);
        corner[2] = 32'(it.face_v2);
        unit_normal(corner[0], corner[1], corner[2], nrm, degen);
        for (int c = 0; c < 3; c++)
          for (int k = 0; k < 3; k++) shadow_nrm[corner[c]][k] = nrm[k];
        res.normal_x   = nrm[0];
        res.normal_y   = nrm[1];
        res.normal_z   = nrm[2];
        res.degenerate = degen;
        res.mesh_done  = it.last_face;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Presents one item and holds it until the engine takes it.
  task automatic send_item(input ffn_in_t it, input bit typed, input ffn_out_t want);
    ffn_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (apply_item(it, res)) pending_results.push_back(typed ? want : res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic ffn_in_t blank_item(input ffn_op_e op);
    ffn_in_t it;
    it = '0;
    it.operation = op;
    return it;
  endfunction

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($signed($urandom_range(65535)) - 32768);
      3: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  // Mostly a small working set of vertices so that faces share corners.
  function automatic ffn_in_t random_item();
    ffn_in_t     it;
    int unsigned roll;
    it = '0;
    it.last_face = 1'($urandom_range(1));
    it.pos_x = random_coord();
    it.pos_y = random_coord();
    it.pos_z = random_coord();
    it.face_v0 = 10'($urandom);
    it.face_v1 = 10'($urandom);
    it.face_v2 = 10'($urandom);
    it.vertex_index = 10'($urandom);
    roll = $urandom_range(99);
    if (roll < 30) begin
      it.operation = OP_WRITE;
      if ($urandom_range(3) != 0) it.vertex_index = 10'($urandom_range(31));
    end else if (roll < 75) begin
      it.operation = OP_FACE;
      it.face_v0 = 10'(pick_written());
      it.face_v1 = 10'(pick_written());
      it.face_v2 = 10'(pick_written());
      // A repeated corner gives a degenerate face.
      if ($urandom_range(9) == 0) it.face_v2 = it.face_v1;
    end else if (roll < 96) begin
      it.operation = OP_READ;
      it.vertex_index = 10'(pick_written());
    end else begin
      it.operation = OP_IGNORE;
    end
    return it;
  endfunction

  // Result checking against the oldest waiting expectation.
  always @(posedge clk) begin
    ffn_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: %p", out_data);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_x !== want.read_x) begin
          $error("read_x expected %0d actual %0d", want.read_x, out_data.read_x);
          failures++;
        end
        if (out_data.read_y !== want.read_y) begin
          $error("read_y expected %0d actual %0d", want.read_y, out_data.read_y);
          failures++;
        end
        if (out_data.read_z !== want.read_z) begin
          $error("read_z expected %0d actual %0d", want.read_z, out_data.read_z);
          failures++;
        end
        if (out_data.normal_x !== want.normal_x) begin
          $error("normal_x expected %0d actual %0d", want.normal_x, out_data.normal_x);
          failures++;
        end
        if (out_data.normal_y !== want.normal_y) begin
          $error("normal_y expected %0d actual %0d", want.normal_y, out_data.normal_y);
          failures++;
        end
        if (out_data.normal_z !== want.normal_z) begin
          $error("normal_z expected %0d actual %0d", want.normal_z, out_data.normal_z);
          failures++;
        end
        if (out_data.degenerate !== want.degenerate) begin
          $error("degenerate expected %0b actual %0b", want.degenerate, out_data.degenerate);
          failures++;
        end
        if (out_data.mesh_done !== want.mesh_done) begin
          $error("mesh_done expected %0b actual %0b", want.mesh_done, out_data.mesh_done);
          failures++;
        end
      end
    end
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: too long without any item crossing either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t   rows [$];
    stim_row_t   row;
    ffn_out_t    nothing;

    nothing = '0;
    for (int v = 0; v < VERTEX_COUNT; v++) begin
      for (int k = 0; k < 3; k++) begin
        shadow_pos[v][k] = '0;
        shadow_nrm[v][k] = '0;
      end
      pos_written[v] = 1'b0;
    end

    // Directed table. Rows marked typed carry a result read straight off the spec.
    row.typed = 1'b0;
    row.want = nothing;
    row.item = blank_item(OP_WRITE);
    rows.push_back(row);                                   // vertex 0 at the origin
    row.item.vertex_index = 10'd1; row.item.pos_x = 32'sh00010000;
    rows.push_back(row);                                   // vertex 1 at unit x
    row.item = blank_item(OP_WRITE);
    row.item.vertex_index = 10'd2; row.item.pos_y = 32'sh00010000;
    rows.push_back(row);                                   // vertex 2 at unit y
    row.item = blank_item(OP_READ);
    row.typed = 1'b1;
    rows.push_back(row);                                   // fresh normal reads as zero
    row.item = blank_item(OP_FACE);
    row.item.face_v1 = 10'd1; row.item.face_v2 = 10'd2;
    row.want = nothing; row.want.normal_z = 32'sh40000000;
    rows.push_back(row);                                   // unit triangle points along +z
    row.item = blank_item(OP_FACE);
    row.item.last_face = 1'b1;
    row.want = nothing; row.want.degenerate = 1'b1; row.want.mesh_done = 1'b1;
    rows.push_back(row);                                   // all corners equal: zero normal
    row.item = blank_item(OP_READ);
    row.item.vertex_index = 10'd1;
    row.want = nothing; row.want.read_x = 32'sh00010000; row.want.normal_z = 32'sh40000000;
    rows.push_back(row);
    row.item = blank_item(OP_READ);
    row.want = nothing;
    rows.push_back(row);                                   // vertex 0 got the zero normal
    row.typed = 1'b0;
    row.item = blank_item(OP_WRITE);
    row.item.vertex_index = 10'd3;
    row.item.pos_x = 32'sh7FFFFFFF; row.item.pos_y = 32'sh7FFFFFFF;
    row.item.pos_z = 32'sh7FFFFFFF;
    rows.push_back(row);
    row.item.vertex_index = 10'd4;
    row.item.pos_x = 32'sh80000000; row.item.pos_y = 32'sh80000000;
    row.item.pos_z = 32'sh80000000;
    rows.push_back(row);
    row.item.vertex_index = 10'd1023;
    row.item.pos_x = 32'sh7FFFFFFF; row.item.pos_y = 32'sh80000000; row.item.pos_z = '0;
    rows.push_back(row);
    row.item = blank_item(OP_FACE);
    row.item.face_v0 = 10'd3; row.item.face_v1 = 10'd4; row.item.face_v2 = 10'd1023;
    rows.push_back(row);                                   // widest possible differences
    row.item.face_v0 = 10'd4; row.item.face_v1 = 10'd1023; row.item.face_v2 = 10'd3;
    row.item.last_face = 1'b1;
    rows.push_back(row);
    row.item.face_v0 = 10'd0; row.item.face_v1 = 10'd3; row.item.face_v2 = 10'd4;
    rows.push_back(row);                                   // collinear through the origin
    row.item = blank_item(OP_IGNORE);
    row.item.vertex_index = 10'd3;
    rows.push_back(row);                                   // unused code gives nothing
    row.item = blank_item(OP_READ);
    row.item.vertex_index = 10'd1023;
    rows.push_back(row);
    row.item.vertex_index = 10'd3;
    rows.push_back(row);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 63;
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    // Hold off until the engine has emptied, then start the random part.
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      ffn_in_t it;
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 20;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      it = random_item();
      send_item(it, 1'b0, nothing);
      if (n == RANDOM_ITEMS / 2) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
